FILE: sv/rhc_pkg.sv
// rhc_pkg: widths, hue constants and pipeline stage types for the rgb to hsv converter
// no dependencies; used by the channel interfaces and the converter top level
`timescale 1ns / 1ps

package rhc_pkg;

   // field widths
   localparam int CHAN_W = 8;                 // one colour channel
   localparam int HUE_W  = 15;                // hue in 1/64 degree
   localparam int HQ_W   = 12;                // hue quotient bits, quotient <= 3840
   localparam int SQ_W   = 8;                 // saturation quotient bits
   localparam int HNUM_W = CHAN_W + HQ_W;     // hue dividend
   localparam int SNUM_W = CHAN_W + SQ_W;     // saturation dividend

   // hue constants in 1/64 degree
   localparam logic [HNUM_W-1:0] HUE_SIXTH    = HNUM_W'(3840);
   localparam logic [HUE_W-1:0]  HUE_FULL     = HUE_W'(23040);
   localparam logic [HUE_W-1:0]  SECTOR_GREEN = HUE_W'(7680);
   localparam logic [HUE_W-1:0]  SECTOR_BLUE  = HUE_W'(15360);

   // saturation full scale
   localparam logic [SNUM_W-1:0] SAT_SCALE = SNUM_W'(255);

   // which channel holds the maximum
   typedef enum logic [1:0] {
      SEC_RED,
      SEC_GREEN,
      SEC_BLUE
   } sector_type;

   // one stage of the divider pipeline, both divisions side by side
   typedef struct packed {
      logic              valid;
      logic [CHAN_W-1:0] hrem;     // hue partial remainder
      logic [HQ_W-1:0]   hbits;    // hue dividend bits still to bring down
      logic [HQ_W-1:0]   hquo;     // hue quotient so far
      logic [CHAN_W-1:0] hden;     // max - min
      logic [CHAN_W-1:0] srem;     // saturation partial remainder
      logic [SQ_W-1:0]   sbits;    // saturation dividend bits still to bring down
      logic [SQ_W-1:0]   squo;     // saturation quotient so far
      logic [CHAN_W-1:0] sden;     // max, also the brightness
      logic              neg;      // channel difference is negative
      sector_type        sector;
      logic              grey;     // max equals min
   } rhc_stage_type;

   // output register
   typedef struct packed {
      logic              valid;
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
   } rhc_out_type;

endpackage

FILE: sv/rhc_if.sv
// rhc_rgb_if and rhc_hsv_if: valid/ready channels carrying an rgb pixel and an hsv result
// depends on rhc_pkg for field widths
`timescale 1ns / 1ps

interface rhc_rgb_if import rhc_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if import rhc_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [CHAN_W-1:0] saturation;
   logic [CHAN_W-1:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink (input valid, input hue, input saturation, input brightness,
                 output ready);
endinterface

FILE: sv/rgb_to_hsv_converter.sv
// rgb_to_hsv_converter: pipelined rgb to hsv pixel conversion
// depends on rhc_pkg and the channel interfaces in rhc_if.sv
`timescale 1ns / 1ps

// Usage
//   req_chan takes one pixel (red, green, blue, 8 bits each) per transfer.
//   rsp_chan gives one result per pixel, in order: hue in 1/64 degree
//   (0..23039), saturation (0..255) and brightness (the largest channel).
//   Stages: front stage, twelve divider stages and the output register.
//   Throughput: one pixel per clock unless rsp_chan stalls. Both divisions
//   are restoring dividers unrolled one quotient bit per stage, twelve
//   stages for the hue quotient, the saturation quotient finishing in
//   the first eight.
//   Stalls: each stage advances when the next one is empty or moving, so a
//   held rsp_chan.ready first fills bubbles; req_chan.ready falls only once
//   every stage holds a pixel. Nothing is dropped or repeated.
//   Reset (synchronous, active high) empties every stage; there is no other
//   state and no configuration.
module rgb_to_hsv_converter import rhc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rhc_rgb_if.sink    req_chan,
   rhc_hsv_if.source  rsp_chan
);

   localparam int N_STG = HQ_W;

   rhc_stage_type     st_ff [0:N_STG];
   rhc_stage_type     st_in [0:N_STG];
   logic [N_STG+1:0]  adv;
   rhc_out_type       out_ff;
   rhc_out_type       out_in;

   // front stage: max, min, sector and both dividends
   logic [CHAN_W-1:0] r, g, b, mx, mn, dlt, pa, pb, adiff;
   logic              red_max, green_max, neg;
   sector_type        sec;
   logic [HNUM_W-1:0] hnum;
   logic [SNUM_W-1:0] snum;

   always_comb begin
      r = req_chan.red;
      g = req_chan.green;
      b = req_chan.blue;
      red_max   = (r >= g) && (r >= b);
      green_max = !red_max && (g >= b);
      if (red_max) begin
         mx = r; sec = SEC_RED; pa = g; pb = b;
      end else if (green_max) begin
         mx = g; sec = SEC_GREEN; pa = b; pb = r;
      end else begin
         mx = b; sec = SEC_BLUE; pa = r; pb = g;
      end
      mn    = (r < g) ? r : g;
      mn    = (b < mn) ? b : mn;
      dlt   = mx - mn;
      neg   = pa < pb;
      adiff = neg ? (pb - pa) : (pa - pb);
      hnum  = HNUM_W'(adiff) * HUE_SIXTH;
      snum  = SNUM_W'(dlt) * SAT_SCALE;

      st_in[0].valid  = req_chan.valid;
      st_in[0].hrem   = hnum[HNUM_W-1:HQ_W];
      st_in[0].hbits  = hnum[HQ_W-1:0];
      st_in[0].hquo   = '0;
      st_in[0].hden   = dlt;
      st_in[0].srem   = snum[SNUM_W-1:SQ_W];
      st_in[0].sbits  = snum[SQ_W-1:0];
      st_in[0].squo   = '0;
      st_in[0].sden   = mx;
      st_in[0].neg    = neg;
      st_in[0].sector = sec;
      st_in[0].grey   = (dlt == '0);
   end

   // divider stages, one hue quotient bit per stage, one saturation quotient bit in the first eight
   for (genvar k = 1; k <= N_STG; k++) begin : g_div
      logic [CHAN_W:0] ht;
      logic [CHAN_W:0] st;
      logic            hge;
      logic            sge;

      always_comb begin
         st_in[k] = st_ff[k-1];

         // hue: bring down one bit, subtract when it fits
         ht  = {st_ff[k-1].hrem, st_ff[k-1].hbits[HQ_W-1]};
         hge = ht >= {1'b0, st_ff[k-1].hden};
         st_in[k].hrem  = hge ? CHAN_W'(ht - {1'b0, st_ff[k-1].hden}) : ht[CHAN_W-1:0];
         st_in[k].hbits = {st_ff[k-1].hbits[HQ_W-2:0], 1'b0};
         st_in[k].hquo  = {st_ff[k-1].hquo[HQ_W-2:0], hge};

         // saturation: same step, done after its eighth bit
         st  = {st_ff[k-1].srem, st_ff[k-1].sbits[SQ_W-1]};
         sge = st >= {1'b0, st_ff[k-1].sden};
         if (k <= SQ_W) begin
            st_in[k].srem  = sge ? CHAN_W'(st - {1'b0, st_ff[k-1].sden}) : st[CHAN_W-1:0];
            st_in[k].sbits = {st_ff[k-1].sbits[SQ_W-2:0], 1'b0};
            st_in[k].squo  = {st_ff[k-1].squo[SQ_W-2:0], sge};
         end
      end
   end

   // stage enables: a stage moves when it is empty or the next one moves
   always_comb begin
      adv[N_STG+1] = !out_ff.valid || rsp_chan.ready;
      for (int i = N_STG; i >= 0; i--) begin
         adv[i] = !st_ff[i].valid || adv[i+1];
      end
   end

   assign req_chan.ready = adv[0];

   // pipeline registers, only the valid bits are cleared
   always_ff @(posedge clock) begin
      for (int i = 0; i <= N_STG; i++) begin
         if (reset) begin
            st_ff[i].valid <= 1'b0;
         end else if (adv[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   // final stage: sector offset, sign, wrap and the grey and black cases
   logic [HUE_W-1:0] q;

   always_comb begin
      q = HUE_W'(st_ff[N_STG].hquo);
      out_in.valid = st_ff[N_STG].valid;
      case (st_ff[N_STG].sector)
         SEC_RED: begin
            out_in.hue = (st_ff[N_STG].neg && (q != '0)) ? (HUE_FULL - q) : q;
         end
         SEC_GREEN: begin
            out_in.hue = st_ff[N_STG].neg ? (SECTOR_GREEN - q) : (SECTOR_GREEN + q);
         end
         SEC_BLUE: begin
            out_in.hue = st_ff[N_STG].neg ? (SECTOR_BLUE - q) : (SECTOR_BLUE + q);
         end
         default: begin
            out_in.hue = '0;
         end
      endcase
      if (st_ff[N_STG].grey) begin
         out_in.hue = '0;
      end
      out_in.saturation = (st_ff[N_STG].sden == '0) ? '0 : st_ff[N_STG].squo;
      out_in.brightness = st_ff[N_STG].sden;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (adv[N_STG+1]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid      = out_ff.valid;
   assign rsp_chan.hue        = out_ff.hue;
   assign rsp_chan.saturation = out_ff.saturation;
   assign rsp_chan.brightness = out_ff.brightness;

   // checks
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.hue < HUE_FULL))
      else $error("hue out of range");

   a_black_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.brightness == '0)) |->
      ((rsp_chan.saturation == '0) && (rsp_chan.hue == '0)))
      else $error("black pixel with non-zero hue or saturation");

   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.saturation == '0)) |-> (rsp_chan.hue == '0))
      else $error("unsaturated pixel with non-zero hue");

   a_hue_quotient: assert property (@(posedge clock) disable iff (reset)
      (st_ff[N_STG].valid && !st_ff[N_STG].grey) |->
      (HNUM_W'(st_ff[N_STG].hquo) <= HUE_SIXTH))
      else $error("hue quotient above one sector");

endmodule
